[hw/rtl/indexed_list_engine_unit_assert.svh]
// assertion macros used by the list engine sequencer
`ifndef INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH
`define INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LLE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");

// next-cycle implication, checked outside reset
`define LLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

[hw/rtl/lle_pkg.sv]
package lle_pkg;

	// default number of slots
	localparam int DEF_CAPACITY = 256;

	// operation codes
	localparam logic [2:0] OP_GET      = 3'd0;
	localparam logic [2:0] OP_ADD_HEAD = 3'd1;
	localparam logic [2:0] OP_ADD_TAIL = 3'd2;
	localparam logic [2:0] OP_ADD_AT   = 3'd3;
	localparam logic [2:0] OP_DEL_AT   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] position;
		logic signed [31:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               found;
		logic [1:0]         status;
		logic [8:0]         element_count;
	} rsp_item_t;

	// handshake between sequencer and result register
	typedef struct packed {
		logic busy;
		logic result_valid;
	} seq_status_t;

endpackage

[hw/rtl/lle_ram.sv]
module lle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/lle_seq.sv]
module lle_seq #(
	parameter int CAPACITY = lle_pkg::DEF_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_take,
	input  lle_pkg::cmd_item_t  cmd,
	input  logic                result_take,
	output lle_pkg::seq_status_t stat,
	output lle_pkg::rsp_item_t  result
);
	import lle_pkg::*;
	`include "indexed_list_engine_unit_assert.svh"

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int PW     = (CNT_W > 15) ? CNT_W + 1 : 16;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ALLOC  = 4'd1;
	localparam logic [3:0] S_WALK   = 4'd2;
	localparam logic [3:0] S_GET    = 4'd3;
	localparam logic [3:0] S_INS_M  = 4'd4;
	localparam logic [3:0] S_INS_M2 = 4'd5;
	localparam logic [3:0] S_INS_T  = 4'd6;
	localparam logic [3:0] S_INS_T2 = 4'd7;
	localparam logic [3:0] S_DEL    = 4'd8;
	localparam logic [3:0] S_RESP   = 4'd9;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  cnt_q, hw_q, target_q, walk_cnt_q;
	logic [SLOT_W-1:0] head_q, tail_q, new_q, s_q, p_q;
	logic [2:0]        op_q;
	logic [31:0]       val_q, rd_q;
	logic              first_q, found_q;
	logic [1:0]        status_q;

	// memory ports
	logic              val_we, nxt_we, prv_we, free_we;
	logic [SLOT_W-1:0] val_waddr, nxt_waddr, prv_waddr, free_waddr;
	logic [31:0]       val_wdata;
	logic [SLOT_W-1:0] nxt_wdata, prv_wdata, free_wdata;
	logic [SLOT_W-1:0] rd_addr, free_raddr;
	logic [31:0]       val_rdata;
	logic [SLOT_W-1:0] nxt_rdata, prv_rdata, free_rdata;

	// decode of the incoming item
	logic              pos_neg, pos_lt, pos_le, ins_ok, walk_done;
	logic [PW-1:0]     pos_ext, cnt_ext;
	logic [CNT_W-1:0]  pos_cnt, target_d;
	logic [1:0]        status_d;
	logic [3:0]        accept_next;
	logic [SLOT_W-1:0] cur;

	assign pos_neg = cmd.position[15];
	assign pos_ext = PW'(cmd.position[14:0]);
	assign cnt_ext = PW'(cnt_q);
	assign pos_lt  = !pos_neg && (pos_ext < cnt_ext);
	assign pos_le  = !pos_neg && (pos_ext <= cnt_ext);
	assign pos_cnt = CNT_W'(pos_ext);

	always_comb begin
		target_d    = pos_cnt;
		status_d    = ST_DONE;
		ins_ok      = 1'b1;
		accept_next = S_RESP;
		unique case (cmd.op) inside
			OP_GET, OP_DEL_AT: begin
				if (pos_lt) begin
					accept_next = S_WALK;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_AT: begin
				if (cmd.op == OP_ADD_HEAD) begin
					target_d = '0;
				end else if (cmd.op == OP_ADD_TAIL) begin
					target_d = cnt_q;
				end else if (pos_neg) begin
					target_d = '0;
				end else if (!pos_le) begin
					ins_ok = 1'b0;
				end
				if (!ins_ok) begin
					status_d = ST_RANGE;
				end else if (cnt_q == CAP_CNT) begin
					status_d = ST_FULL;
				end else begin
					accept_next = S_ALLOC;
				end
			end
			default: begin
				accept_next = S_RESP;
			end
		endcase
	end

	// walk unit: one link per cycle from the head
	assign cur        = first_q ? head_q : nxt_rdata;
	assign walk_done  = (walk_cnt_q == target_q);
	assign rd_addr    = cur;
	assign free_raddr = SLOT_W'(hw_q - cnt_q - 1'b1);

	// memory writes per sequencer step
	always_comb begin
		val_we     = 1'b0;
		nxt_we     = 1'b0;
		prv_we     = 1'b0;
		free_we    = 1'b0;
		val_waddr  = new_q;
		val_wdata  = val_q;
		nxt_waddr  = new_q;
		nxt_wdata  = s_q;
		prv_waddr  = new_q;
		prv_wdata  = p_q;
		free_waddr = SLOT_W'(hw_q - cnt_q);
		free_wdata = s_q;
		unique case (state_q)
			S_INS_M: begin
				val_we    = 1'b1;
				nxt_we    = 1'b1;
				prv_we    = 1'b1;
				prv_waddr = s_q;
				prv_wdata = new_q;
			end
			S_INS_M2: begin
				prv_we    = 1'b1;
				nxt_we    = (target_q != '0);
				nxt_waddr = p_q;
				nxt_wdata = new_q;
			end
			S_INS_T: begin
				val_we    = 1'b1;
				nxt_we    = 1'b1;
				nxt_wdata = '0;
				prv_we    = 1'b1;
				prv_wdata = tail_q;
			end
			S_INS_T2: begin
				nxt_we    = (cnt_q != '0);
				nxt_waddr = tail_q;
				nxt_wdata = new_q;
			end
			S_DEL: begin
				nxt_we    = (target_q != '0);
				nxt_waddr = prv_rdata;
				nxt_wdata = nxt_rdata;
				prv_we    = ((target_q + 1'b1) != cnt_q);
				prv_waddr = nxt_rdata;
				prv_wdata = prv_rdata;
				free_we   = 1'b1;
			end
			default: begin
				val_we = 1'b0;
			end
		endcase
	end

	lle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(rd_addr), .rdata(val_rdata)
	);

	lle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(rd_addr), .rdata(nxt_rdata)
	);

	lle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(rd_addr), .rdata(prv_rdata)
	);

	// stack of released slots, depth is hw_q - cnt_q
	lle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
		.raddr(free_raddr), .rdata(free_rdata)
	);

	// sequencer and list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			hw_q    <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= accept_next;
					end
				end
				S_ALLOC: begin
					if (hw_q == cnt_q) begin
						hw_q <= hw_q + 1'b1;
					end
					state_q <= (target_q >= cnt_q) ? S_INS_T : S_WALK;
				end
				S_WALK: begin
					if (walk_done) begin
						if (op_q == OP_GET) begin
							state_q <= S_GET;
						end else if (op_q == OP_DEL_AT) begin
							state_q <= S_DEL;
						end else begin
							state_q <= S_INS_M;
						end
					end
				end
				S_GET: begin
					state_q <= S_RESP;
				end
				S_INS_M: begin
					state_q <= S_INS_M2;
				end
				S_INS_M2: begin
					if (target_q == '0) begin
						head_q <= new_q;
					end
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_RESP;
				end
				S_INS_T: begin
					state_q <= S_INS_T2;
				end
				S_INS_T2: begin
					if (cnt_q == '0) begin
						head_q <= new_q;
					end
					tail_q  <= new_q;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_RESP;
				end
				S_DEL: begin
					if (target_q == '0) begin
						head_q <= nxt_rdata;
					end
					if ((target_q + 1'b1) == cnt_q) begin
						tail_q <= prv_rdata;
					end
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (result_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					op_q       <= cmd.op;
					val_q      <= cmd.value;
					target_q   <= target_d;
					walk_cnt_q <= '0;
					first_q    <= 1'b1;
					rd_q       <= '0;
					found_q    <= 1'b0;
					status_q   <= status_d;
				end
			end
			S_ALLOC: begin
				new_q <= (hw_q == cnt_q) ? hw_q[SLOT_W-1:0] : free_rdata;
			end
			S_WALK: begin
				if (walk_done) begin
					s_q <= cur;
				end else begin
					walk_cnt_q <= walk_cnt_q + 1'b1;
					first_q    <= 1'b0;
				end
			end
			S_GET: begin
				rd_q    <= val_rdata;
				found_q <= 1'b1;
			end
			S_INS_M: begin
				p_q <= prv_rdata;
			end
			default: begin
				first_q <= first_q;
			end
		endcase
	end

	assign stat.busy           = (state_q != S_IDLE);
	assign stat.result_valid   = (state_q == S_RESP);
	assign result.read_value   = signed'(rd_q);
	assign result.found        = found_q;
	assign result.status       = status_q;
	assign result.element_count = 9'(cnt_q);

	`LLE_ASSERT_NOW(a_stack_depth, 1'b1, (hw_q >= cnt_q) && (hw_q <= CAP_CNT))
	`LLE_ASSERT_NOW(a_walk_bound, state_q == S_WALK, walk_cnt_q <= target_q)
	`LLE_ASSERT_NEXT(a_cnt_idle, state_q == S_IDLE, $stable(cnt_q))
	`LLE_ASSERT_NOW(a_del_nonempty, state_q == S_DEL, (cnt_q != '0) && (target_q < cnt_q))

endmodule

[hw/rtl/indexed_list_engine_unit.sv]
// Indexed list engine: keeps an ordered list of up to CAPACITY signed 32-bit values as a
// doubly linked list over slot memories, one operation per item and one result per item.
// Items are taken one at a time; cmd_stall stays high until the result of the current item
// has moved into the output register, which lets the next item in while that result waits.
// Cost is set by the link walk through the next-pointer memory, one link per cycle from the
// head. Get and delete at index k walk k links, as does an insert before index k (a head
// insert into a non-empty list is the k of zero case); an append or an insert into an empty
// list walks none, and an ignored, dropped or unused-op item goes straight to its result.
// The worst case is an insert before the last element of a list one short of full. No
// clearing pass follows reset; the block is ready at once.
module indexed_list_engine_unit #(
	parameter int CAPACITY = lle_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  lle_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lle_pkg::rsp_item_t rsp
);
	import lle_pkg::*;

	seq_status_t seq_stat;
	rsp_item_t   seq_result;
	logic        cmd_take, result_take;
	logic        rsp_valid_q;
	rsp_item_t   rsp_q;

	// input side handshake
	assign cmd_stall   = seq_stat.busy;
	assign cmd_take    = cmd_valid && !seq_stat.busy;
	assign result_take = !rsp_valid_q || !rsp_stall;

	lle_seq #(.CAPACITY(CAPACITY)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_take(cmd_take),
		.cmd(cmd),
		.result_take(result_take),
		.stat(seq_stat),
		.result(seq_result)
	);

	// output register, holds a result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (result_take) begin
			rsp_valid_q <= seq_stat.result_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (result_take && seq_stat.result_valid) begin
			rsp_q <= seq_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[dv/indexed_list_engine_unit_tb.sv]
module indexed_list_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lle_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int MAX_REPORTS = 50;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 100;

	// op codes the block treats as no-ops
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// predicted list contents and results still owed by the block
	logic signed [31:0] list_model[$];
	rsp_item_t          pending_rsp_q[$];

	logic [2:0] add_ops [3] = '{OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_AT};

	int          mismatch_count = 0;
	int unsigned cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	indexed_list_engine_unit dut (
		.clk,
		.arst_n,
		.cmd_valid,
		.cmd_stall,
		.cmd,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// cycle counter and run limit
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("indexed_list_engine_unit_tb failed");
		$finish;
	end

	// apply one operation to the list copy and return the result it gives
	function automatic rsp_item_t apply_list_op(input cmd_item_t c);
		rsp_item_t r;
		int        p;
		int        cnt;
		int        at;
		bit        ok;
		r = '0;
		r.status = ST_DONE;
		p = c.position;
		cnt = list_model.size();
		case (c.op)
			OP_GET: begin
				if (p >= 0 && p < cnt) begin
					r.read_value = list_model[p];
					r.found = 1'b1;
				end else begin
					r.status = ST_RANGE;
				end
			end
			OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_AT: begin
				ok = 1'b1;
				at = 0;
				if (c.op == OP_ADD_TAIL) begin
					at = cnt;
				end else if (c.op == OP_ADD_AT) begin
					if (p <= 0) begin
						at = 0;
					end else if (p <= cnt) begin
						at = p;
					end else begin
						ok = 1'b0;
						r.status = ST_RANGE;
					end
				end
				// range check wins over the full check
				if (ok) begin
					if (cnt >= CAPACITY)
						r.status = ST_FULL;
					else
						list_model.insert(at, c.value);
				end
			end
			OP_DEL_AT: begin
				if (p >= 0 && p < cnt)
					list_model.delete(p);
				else
					r.status = ST_RANGE;
			end
			default: begin
			end
		endcase
		r.element_count = 9'(list_model.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
				want);
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				report_mismatch("result with no item pending, count", rsp.element_count, 0);
			end else begin
				want = pending_rsp_q.pop_front();
				if (rsp.read_value !== want.read_value)
					report_mismatch("read_value", rsp.read_value, want.read_value);
				if (rsp.found !== want.found)
					report_mismatch("found", rsp.found, want.found);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.element_count !== want.element_count)
					report_mismatch("element_count", rsp.element_count, want.element_count);
			end
		end
	end

	// receiver stall, with long hold-offs counted here
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// offer one item from a falling edge, return at the falling edge after it is taken
	task automatic send_cmd(input cmd_item_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (cmd_stall);
		pending_rsp_q.push_back(apply_list_op(c));
		@(negedge clk);
	endtask

	task automatic send_op(input logic [2:0] op, input int pos, input logic [31:0] val);
		cmd_item_t c;
		c.op = op;
		c.position = 16'(pos);
		c.value = val;
		send_cmd(c);
	endtask

	// stop offering items until every result is back
	task automatic wait_for_results();
		cmd_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// mostly in range, some just past the end, some negative, some anything
	function automatic int pick_position();
		int cnt;
		int sel;
		cnt = list_model.size();
		sel = $urandom_range(99);
		if (sel < 80)
			return $urandom_range(cnt, 0);
		else if (sel < 86)
			return cnt + $urandom_range(3, 1);
		else if (sel < 92)
			return -int'($urandom_range(3, 1));
		else
			return int'(16'($urandom));
	endfunction

	function automatic cmd_item_t rand_cmd(input int grow_pct);
		cmd_item_t c;
		int        sel;
		sel = $urandom_range(99);
		c.position = 16'(pick_position());
		c.value = $urandom;
		if (sel < 4)
			c.op = 3'($urandom_range(OP_RSVD7, OP_RSVD5));
		else if (sel < 4 + grow_pct)
			c.op = add_ops[$urandom_range(2)];
		else if ($urandom_range(99) < 55)
			c.op = OP_GET;
		else
			c.op = OP_DEL_AT;
		return c;
	endfunction

	// edges of every field and each special case, starting from an empty list
	task automatic test_directed();
		send_op(OP_GET, 0, 32'h1234_5678);
		send_op(OP_DEL_AT, 0, 32'h0);
		send_op(OP_ADD_AT, 1, 32'hdead_beef);
		send_op(OP_ADD_AT, -32768, 32'h8000_0000);
		send_op(OP_ADD_TAIL, 0, 32'h7fff_ffff);
		send_op(OP_ADD_HEAD, 0, 32'h0000_0000);
		send_op(OP_ADD_AT, list_model.size(), 32'hffff_ffff);
		send_op(OP_ADD_AT, 0, 32'h0000_0001);
		send_op(OP_ADD_AT, 2, 32'h5555_5555);
		send_op(OP_ADD_AT, 32767, 32'haaaa_aaaa);
		send_op(OP_GET, 0, 32'h0);
		send_op(OP_GET, list_model.size() - 1, 32'h0);
		send_op(OP_GET, list_model.size(), 32'h0);
		send_op(OP_GET, -1, 32'h0);
		send_op(OP_GET, 32767, 32'h0);
		send_op(OP_GET, -32768, 32'h0);
		send_op(OP_DEL_AT, 32767, 32'h0);
		send_op(OP_DEL_AT, -32768, 32'h0);
		send_op(OP_DEL_AT, list_model.size() - 1, 32'h0);
		send_op(OP_DEL_AT, 0, 32'h0);
		send_op(OP_DEL_AT, 1, 32'h0);
		send_op(OP_RSVD5, 1, $urandom);
		send_op(OP_RSVD6, -1, $urandom);
		send_op(OP_RSVD7, 32767, $urandom);
		send_op(OP_GET, 1, 32'h0);
		wait_for_results();
	endtask

	// fill every slot, poke the full store, then empty it again
	task automatic test_fill_to_capacity();
		while (list_model.size() < CAPACITY) begin
			if ($urandom_range(9) == 0)
				send_op(OP_ADD_AT, pick_position(), $urandom);
			else
				send_op(add_ops[$urandom_range(1)], 0, $urandom);
		end
		send_op(OP_ADD_HEAD, 0, $urandom);
		send_op(OP_ADD_TAIL, 0, $urandom);
		send_op(OP_ADD_AT, CAPACITY / 2, $urandom);
		send_op(OP_ADD_AT, CAPACITY, $urandom);
		send_op(OP_ADD_AT, -5, $urandom);
		send_op(OP_ADD_AT, CAPACITY + 1, $urandom);
		send_op(OP_GET, CAPACITY - 1, 32'h0);
		send_op(OP_GET, CAPACITY, 32'h0);
		send_op(OP_DEL_AT, CAPACITY - 1, 32'h0);
		send_op(OP_ADD_AT, CAPACITY - 2, 32'h7fff_ffff);
		send_op(OP_GET, CAPACITY - 2, 32'h0);
		send_op(OP_GET, CAPACITY - 1, 32'h0);
		// drain mostly from the head so freed slots get reused later
		while (list_model.size() > 0) begin
			if ($urandom_range(3) == 0)
				send_op(OP_DEL_AT, $urandom_range(list_model.size() - 1, 0), 32'h0);
			else
				send_op(OP_DEL_AT, 0, 32'h0);
		end
		wait_for_results();
	endtask

	// receiver holds off while items keep coming, so the input backs up
	task automatic test_backpressure();
		hold_req++;
		repeat (12)
			send_cmd(rand_cmd(50));
		wait_for_results();
	endtask

	// random items under one idling setting, growing then shrinking the list
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n_items / 2)
			send_cmd(rand_cmd(60));
		repeat (n_items - n_items / 2)
			send_cmd(rand_cmd(25));
		wait_for_results();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// test sequence
	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_fill_to_capacity();
		test_backpressure();
		test_random_phase(0, 0, PHASE_ITEMS);
		test_random_phase(63, 0, PHASE_ITEMS);
		test_random_phase(0, 63, PHASE_ITEMS);
		test_random_phase(28, 28, PHASE_ITEMS);
		test_backpressure();
		wait_for_results();
		// catch any stray result after the last one expected
		repeat (CAPACITY + 40) @(posedge clk);
		if (pending_rsp_q.size() != 0)
			report_mismatch("results never delivered", 0, pending_rsp_q.size());
		if (mismatch_count == 0)
			$display("indexed_list_engine_unit_tb passed");
		else
			$display("indexed_list_engine_unit_tb failed");
		$finish;
	end

endmodule

[indexed_list_engine_unit.f]
+incdir+hw/rtl
hw/rtl/lle_pkg.sv
hw/rtl/lle_ram.sv
hw/rtl/lle_seq.sv
hw/rtl/indexed_list_engine_unit.sv
dv/indexed_list_engine_unit_tb.sv
